// ----- rtl/core/wbps_pkg.sv -----
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

    // Widths fixed by the register map.
    localparam int unsigned PAT_CAP     = 16;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned CARE_W      = 16;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_IDX_W   = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [CARE_W-1:0] CARE_MASK_RESET      = 16'hFFFF;
    localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = 5'd1;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CARE_W-1:0]     care_mask;
        logic [LEN_W-1:0]      pattern_length;
        logic                  first_only;
    } wbps_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/wildcard_byte_pattern_scanner.sv -----
// Top level of the wildcard byte pattern scanner.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------
//   in      | in_valid / in_ready    | data_byte, last_in_region
//   out     | out_valid / out_ready  | match_offset
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle unless a waiting result stalls: a byte is registered on
// acceptance, compared against the pattern from the input register and any
// hit lands in the result register.
// Reset clears the window, the region offset and the hit bookkeeping.
// A waiting result stalls the compare stage, which in turn holds in_ready
// low only when the input register is also full.
`default_nettype none

module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = 16,
    parameter int unsigned OFFSET_BITS = 28
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   last_in_region,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [OFFSET_BITS-1:0]      match_offset,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned PAT_LIMIT = (MAX_PATTERN < PAT_CAP) ? MAX_PATTERN : PAT_CAP;
    localparam int unsigned POS_W     = OFFSET_BITS + 1;

    wbps_cfg_t cfg;

    // Input register.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;

    // Region state.
    logic [PAT_LIMIT-1:0][7:0] window_reg;
    logic [PAT_LIMIT-1:0][7:0] window_next;
    logic [OFFSET_BITS-1:0]    pos_reg;
    logic [OFFSET_BITS-1:0]    pos_next;
    logic [OFFSET_BITS-1:0]    next_allowed_reg;
    logic [OFFSET_BITS-1:0]    next_allowed_next;
    logic                      hit_seen_reg;
    logic                      hit_seen_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OFFSET_BITS-1:0] out_offset_reg;

    logic                   advance;
    logic [LEN_W-1:0]       eff_len;
    logic                   pos_sat;
    logic [POS_W-1:0]       pos_inc;
    logic [POS_W-1:0]       start_wide;
    logic [OFFSET_BITS-1:0] start;
    logic                   can_start;
    logic                   window_hit;
    logic                   report;

    wbps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control: the compare stage moves when the result slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Effective pattern length, clamped to 1..PAT_LIMIT.
    always_comb
    begin
        if (cfg.pattern_length == '0)
            eff_len = LEN_W'(1);
        else if (cfg.pattern_length > LEN_W'(PAT_LIMIT))
            eff_len = LEN_W'(PAT_LIMIT);
        else
            eff_len = cfg.pattern_length;
    end

    // Window including the byte now in the compare stage.
    assign window_next = {window_reg[PAT_LIMIT-2:0], in_byte_reg};

    wbps_window_match #(
        .PAT_LIMIT (PAT_LIMIT)
    ) u_window_match (
        .window  (window_next),
        .cfg     (cfg),
        .eff_len (eff_len),
        .hit     (window_hit)
    );

    // Candidate start offset and the leftmost, non-overlapping rule.
    assign pos_sat    = &pos_reg;
    assign pos_inc    = {1'b0, pos_reg} + POS_W'(1);
    assign start_wide = pos_inc - POS_W'(eff_len);
    assign start      = start_wide[OFFSET_BITS-1:0];
    assign can_start  = !pos_sat && (pos_inc >= POS_W'(eff_len));
    assign report     = can_start && (start >= next_allowed_reg) &&
                        !(cfg.first_only && hit_seen_reg) && window_hit;

    // Region state update; the end of a region clears it after the compare.
    always_comb
    begin
        pos_next          = pos_sat ? pos_reg : pos_inc[OFFSET_BITS-1:0];
        next_allowed_next = report ? pos_inc[OFFSET_BITS-1:0] : next_allowed_reg;
        hit_seen_next     = hit_seen_reg || report;
        if (in_last_reg)
        begin
            pos_next          = '0;
            next_allowed_next = '0;
            hit_seen_next     = 1'b0;
        end
    end

    // Result slot occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = report;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_in_region;
        end
    end

    // Region state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= '0;
            pos_reg          <= '0;
            next_allowed_reg <= '0;
            hit_seen_reg     <= 1'b0;
        end
        else if (advance)
        begin
            window_reg       <= in_last_reg ? '0 : window_next;
            pos_reg          <= pos_next;
            next_allowed_reg <= next_allowed_next;
            hit_seen_reg     <= hit_seen_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && report)
        begin
            out_offset_reg <= start;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_offset = out_offset_reg;

    // A hit inside a region is remembered for first-only mode.
    a_hit_recorded : assert property (@(posedge clk) disable iff (!rst_n)
        advance && report && !in_last_reg |=> hit_seen_reg)
        else $error("hit not recorded in region state");

    // The next permitted start lies past the reported match.
    a_next_past_hit : assert property (@(posedge clk) disable iff (!rst_n)
        advance && report && !in_last_reg |=> next_allowed_reg > out_offset_reg)
        else $error("next permitted start does not pass the reported match");

    // The end of a region leaves the offset and bookkeeping clear.
    a_region_clear : assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> (pos_reg == '0) && !hit_seen_reg &&
                                   (next_allowed_reg == '0))
        else $error("region state not cleared at end of region");

endmodule

`default_nettype wire

// ----- rtl/core/wbps_cfg_regs.sv -----
// Configuration register file of the wildcard byte pattern scanner.
`default_nettype none

module wbps_cfg_regs
    import wbps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output wbps_cfg_t                  cfg
);

    wbps_cfg_t cfg_reg;
    wbps_cfg_t cfg_next;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    cfg_next.pattern_low    = cfg_data;
                CFG_PATTERN_HIGH:   cfg_next.pattern_high   = cfg_data;
                CFG_CARE_MASK:      cfg_next.care_mask      = cfg_data[CARE_W-1:0];
                CFG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[LEN_W-1:0];
                CFG_FIRST_ONLY:     cfg_next.first_only     = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= CARE_MASK_RESET;
            cfg_reg.pattern_length <= PATTERN_LENGTH_RESET;
            cfg_reg.first_only     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wbps_window_match.sv -----
// Parallel wildcard compare of the byte window against the pattern.
`default_nettype none

module wbps_window_match
    import wbps_pkg::*;
#(
    parameter int unsigned PAT_LIMIT = 16
)
(
    input  wire logic [PAT_LIMIT-1:0][7:0] window,
    input  wire wbps_cfg_t                 cfg,
    input  wire logic [LEN_W-1:0]          eff_len,
    output logic                           hit
);

    localparam int unsigned IDX_W = $clog2(PAT_LIMIT);

    logic [2*CFG_DATA_W-1:0] pattern;
    logic [PAT_LIMIT-1:0]    byte_ok;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    // Pattern byte i lines up with window entry (length - 1 - i); the
    // newest byte sits in entry 0.
    for (genvar i = 0; i < PAT_LIMIT; i++)
    begin : g_byte
        logic [LEN_W-1:0] tap_idx;
        logic             in_use;

        assign tap_idx = eff_len - LEN_W'(i + 1);
        assign in_use  = eff_len > LEN_W'(i);
        assign byte_ok[i] = !in_use || !cfg.care_mask[i] ||
                            (window[tap_idx[IDX_W-1:0]] == pattern[8*i +: 8]);
    end

    assign hit = &byte_ok;

endmodule

`default_nettype wire
